>>> design/io_translator_mailbox_macros.svh
// assertion helpers for the io translator mailbox checker
`ifndef IO_TRANSLATOR_MAILBOX_MACROS_SVH
`define IO_TRANSLATOR_MAILBOX_MACROS_SVH

// same-cycle implication, skipped while in reset
`define IOTM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, skipped while in reset
`define IOTM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/iotm_pkg.sv
`default_nettype none
package iotm_pkg;

    localparam int CONTROL_REG_COUNT = 32;
    localparam int BURST_LENGTH      = 256;
    localparam int MSG_BUFFER_SIZE   = 512;

    localparam int CREG_IDX_W = $clog2(CONTROL_REG_COUNT);
    localparam int BURST_W    = $clog2(BURST_LENGTH + 1);
    localparam int MSG_W      = (MSG_BUFFER_SIZE > 2) ? $clog2(MSG_BUFFER_SIZE) : 1;
    localparam int MAP_W      = 31;
    localparam int Q_DEPTH    = 2;
    localparam int Q_PTR_W    = $clog2(Q_DEPTH);
    localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);

    localparam logic [2:0] OP_STATUS  = 3'd0;
    localparam logic [2:0] OP_READ_IN = 3'd1;
    localparam logic [2:0] OP_CTRL    = 3'd2;
    localparam logic [2:0] OP_OUT     = 3'd3;
    localparam logic [2:0] OP_ACK     = 3'd4;

    localparam logic [7:0] STAT_LAST_BYTE  = 8'h04;
    localparam logic [7:0] STAT_RESET_DONE = 8'h08;
    localparam logic [7:0] STAT_READ_MASK  = 8'h7e;
    localparam logic [7:0] ACK_VECTOR      = 8'h58;
    localparam logic [7:0] EMPTY_READ      = 8'hff;

    localparam int CTRL_RESET_BIT = 0;
    localparam int CTRL_COM_BIT   = 1;
    localparam int CTRL_END_BIT   = 2;
    localparam int CTRL_HOLD_BIT  = 7;

    localparam logic [1:0] REASON_NONE  = 2'd0;
    localparam logic [1:0] REASON_BURST = 2'd1;
    localparam logic [1:0] REASON_RESET = 2'd3;

    localparam logic [3:0] GRP_CREG_LO   = 4'h8;
    localparam logic [3:0] GRP_CREG_HI   = 4'h9;
    localparam logic [3:0] GRP_MESSAGE   = 4'hA;
    localparam logic [3:0] GRP_ATN       = 4'hB;

    localparam logic [CREG_IDX_W-1:0] AUX_REG_IDX = CREG_IDX_W'(16);
    localparam logic [7:0] AUX_REG_RESET = 8'h02;
    localparam int         MY_ADDR       = 21;

    typedef enum logic [2:0] {
        ACC_NONE,
        ACC_STATUS,
        ACC_READ_IN,
        ACC_CTRL,
        ACC_OUT,
        ACC_ACK
    } acc_kind_t;

    typedef enum logic [2:0] {
        CMD_STAT_READ,
        CMD_BURST_ARM,
        CMD_AUX_READ,
        CMD_MY_TALK,
        CMD_MY_LISTEN,
        CMD_IGNORE,
        CMD_CREG_READ,
        CMD_KEEP
    } cmd_kind_t;

    typedef enum logic [2:0] {
        ATN_NONE,
        ATN_LISTEN,
        ATN_UNLISTEN,
        ATN_TALK,
        ATN_UNTALK
    } atn_kind_t;

    typedef struct packed {
        acc_kind_t  kind;
        logic [7:0] wdata;
        cmd_kind_t  cmd;
        atn_kind_t  atn;
        logic [4:0] atn_bit;
    } acc_t;

    function automatic logic [7:0] status_entry(input logic [3:0] idx);
        logic [7:0] val;
        case (idx)
            4'h0:    val = 8'h01;
            4'h2:    val = 8'hFC;
            4'h4:    val = 8'h22;
            4'h5:    val = 8'hA0;
            4'h6:    val = 8'h01;
            default: val = 8'h00;
        endcase
        return val;
    endfunction

endpackage
`default_nettype wire

>>> design/iotm_if.sv
`default_nettype none
interface iotm_req_if;
    logic       valid;
    logic       ready;
    logic [2:0] op;
    logic [7:0] wdata;

    modport source (output valid, output op, output wdata, input ready);
    modport sink (input valid, input op, input wdata, output ready);
endinterface

interface iotm_rsp_if;
    import iotm_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [7:0]           rdata;
    logic                 int_request;
    logic [1:0]           int_reason;
    logic [MAP_W-1:0]     listen_map;
    logic [MAP_W-1:0]     talk_map;
    logic                 message_end;
    logic [8:0]           message_length;

    modport source (output valid, output rdata, output int_request, output int_reason,
                    output listen_map, output talk_map, output message_end,
                    output message_length, input ready);
    modport sink (input valid, input rdata, input int_request, input int_reason,
                  input listen_map, input talk_map, input message_end,
                  input message_length, output ready);
endinterface
`default_nettype wire

>>> design/iotm_fifo.sv
`default_nettype none
module iotm_fifo (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                push,
    input  iotm_pkg::acc_t     push_data,
    output logic               full,
    input  wire                pop,
    output iotm_pkg::acc_t     pop_data,
    output logic               not_empty
);
    import iotm_pkg::*;

    acc_t                 slot_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0]   count_reg, count_next;

    assign full      = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? Q_PTR_W'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = pop ? Q_PTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = Q_CNT_W'(count_reg + 1'b1);
        end
        else if (pop && !push)
        begin
            count_next = Q_CNT_W'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end
endmodule
`default_nettype wire

>>> design/iotm_front.sv
`default_nettype none
module iotm_front (
    iotm_req_if.sink        req,
    input  wire             q_full,
    output logic            push,
    output iotm_pkg::acc_t  push_data
);
    import iotm_pkg::*;

    logic [6:0] low7;
    logic [3:0] grp;
    logic [3:0] sub;

    assign req.ready = !q_full;
    assign push      = req.valid && !q_full;
    assign low7      = req.wdata[6:0];
    assign grp       = req.wdata[7:4];
    assign sub       = req.wdata[3:0];

    always_comb
    begin
        push_data.wdata   = req.wdata;
        push_data.atn_bit = req.wdata[4:0];

        case (req.op)
            OP_STATUS:  push_data.kind = ACC_STATUS;
            OP_READ_IN: push_data.kind = ACC_READ_IN;
            OP_CTRL:    push_data.kind = ACC_CTRL;
            OP_OUT:     push_data.kind = ACC_OUT;
            OP_ACK:     push_data.kind = ACC_ACK;
            default:    push_data.kind = ACC_NONE;
        endcase

        // command byte decode
        case (grp)
            4'h0:    push_data.cmd = CMD_STAT_READ;
            4'h2:    push_data.cmd = (sub == 4'h0) ? CMD_BURST_ARM : CMD_KEEP;
            4'h4:
            begin
                case (sub)
                    4'h4:    push_data.cmd = CMD_AUX_READ;
                    4'h5:    push_data.cmd = CMD_MY_TALK;
                    4'h6:    push_data.cmd = CMD_MY_LISTEN;
                    default: push_data.cmd = CMD_KEEP;
                endcase
            end
            4'h5, 4'h6, 4'hC, 4'hD: push_data.cmd = CMD_IGNORE;
            4'h7:    push_data.cmd = CMD_CREG_READ;
            default: push_data.cmd = CMD_KEEP;
        endcase

        // addressing byte decode, parity bit ignored
        if (low7 == 7'h3f)
        begin
            push_data.atn = ATN_UNLISTEN;
        end
        else if (low7 == 7'h5f)
        begin
            push_data.atn = ATN_UNTALK;
        end
        else if (low7[6:5] == 2'b01)
        begin
            push_data.atn = ATN_LISTEN;
        end
        else if (low7[6:5] == 2'b10)
        begin
            push_data.atn = ATN_TALK;
        end
        else
        begin
            push_data.atn = ATN_NONE;
        end
    end
endmodule
`default_nettype wire

>>> design/iotm_exec.sv
`default_nettype none
module iotm_exec (
    input  wire             clk,
    input  wire             rst_n,
    input  wire             q_valid,
    input  iotm_pkg::acc_t  q_data,
    output logic            pop,
    iotm_rsp_if.source      rsp
);
    import iotm_pkg::*;

    logic [7:0]         status_reg, status_next;
    logic               in_full_reg, in_full_next;
    logic [7:0]         mbox_reg [2];
    logic [7:0]         mbox_next [2];
    logic [1:0]         mbox_pos_reg, mbox_pos_next;
    logic [1:0]         mbox_left_reg, mbox_left_next;
    logic [7:0]         aux_reg, aux_next;
    logic [7:0]         last_cmd_reg, last_cmd_next;
    logic [MAP_W-1:0]   listen_reg, listen_next;
    logic [MAP_W-1:0]   talk_reg, talk_next;
    logic [MSG_W-1:0]   msg_cnt_reg, msg_cnt_next;
    logic [BURST_W-1:0] burst_left_reg, burst_left_next;
    logic               burst_on_reg, burst_on_next;
    logic               burst_tail_reg, burst_tail_next;
    logic [7:0]         ctrl_reg, ctrl_next;
    logic [1:0]         pending_reg, pending_next;

    logic               out_valid_reg;
    logic [7:0]         out_rdata_reg, out_rdata_next;
    logic               out_irq_reg, out_irq_next;
    logic [1:0]         out_reason_reg, out_reason_next;
    logic               out_mend_reg, out_mend_next;

    logic [7:0]         v;
    logic [3:0]         last_grp;
    logic [BURST_W-1:0] burst_dec;
    logic [MAP_W-1:0]   atn_mask;

    assign pop                = q_valid && (!out_valid_reg || rsp.ready);
    assign v                  = q_data.wdata;
    assign last_grp           = last_cmd_reg[7:4];
    assign burst_dec          = (burst_left_reg == '0) ? '0 :
                                BURST_W'(burst_left_reg - 1'b1);
    assign atn_mask           = MAP_W'(1) << q_data.atn_bit;

    assign rsp.valid          = out_valid_reg;
    assign rsp.rdata          = out_rdata_reg;
    assign rsp.int_request    = out_irq_reg;
    assign rsp.int_reason     = out_reason_reg;
    assign rsp.listen_map     = listen_reg;
    assign rsp.talk_map       = talk_reg;
    assign rsp.message_end    = out_mend_reg;
    assign rsp.message_length = 9'(msg_cnt_reg);

    always_comb
    begin
        status_next     = status_reg;
        in_full_next    = in_full_reg;
        mbox_next[0]    = mbox_reg[0];
        mbox_next[1]    = mbox_reg[1];
        mbox_pos_next   = mbox_pos_reg;
        mbox_left_next  = mbox_left_reg;
        aux_next        = aux_reg;
        last_cmd_next   = last_cmd_reg;
        listen_next     = listen_reg;
        talk_next       = talk_reg;
        msg_cnt_next    = msg_cnt_reg;
        burst_left_next = burst_left_reg;
        burst_on_next   = burst_on_reg;
        burst_tail_next = burst_tail_reg;
        ctrl_next       = ctrl_reg;
        pending_next    = pending_reg;
        out_rdata_next  = '0;
        out_irq_next    = 1'b0;
        out_reason_next = REASON_NONE;
        out_mend_next   = 1'b0;

        case (q_data.kind)
            ACC_STATUS:
            begin
                out_rdata_next = (status_reg & STAT_READ_MASK) | {7'd0, in_full_reg};
            end
            ACC_READ_IN:
            begin
                out_rdata_next = EMPTY_READ;
                if (mbox_left_reg != 2'd0)
                begin
                    if (in_full_reg)
                    begin
                        out_rdata_next = mbox_reg[mbox_pos_reg[0]];
                        mbox_pos_next  = 2'(mbox_pos_reg + 2'd1);
                        mbox_left_next = 2'(mbox_left_reg - 2'd1);
                        in_full_next   = 1'b0;
                    end
                    if (mbox_left_next == 2'd0)
                    begin
                        status_next = status_reg | STAT_LAST_BYTE;
                    end
                    else
                    begin
                        status_next  = status_reg & ~STAT_LAST_BYTE;
                        in_full_next = 1'b1;
                    end
                end
            end
            ACC_CTRL:
            begin
                ctrl_next = v;
                if (v[CTRL_RESET_BIT] && !ctrl_reg[CTRL_RESET_BIT])
                begin
                    status_next = STAT_RESET_DONE;
                end
                if (ctrl_reg[CTRL_HOLD_BIT] && !v[CTRL_HOLD_BIT])
                begin
                    pending_next    = REASON_RESET;
                    out_irq_next    = 1'b1;
                    out_reason_next = REASON_RESET;
                end
            end
            ACC_OUT:
            begin
                if (burst_on_reg)
                begin
                    burst_left_next = burst_dec;
                    if (burst_dec == '0)
                    begin
                        burst_on_next   = 1'b0;
                        burst_tail_next = 1'b1;
                        pending_next    = REASON_BURST;
                        out_irq_next    = 1'b1;
                        out_reason_next = REASON_BURST;
                    end
                end
                else if (burst_tail_reg)
                begin
                    burst_tail_next = 1'b0;
                end
                else if (ctrl_reg[CTRL_COM_BIT])
                begin
                    last_cmd_next = v;
                    case (q_data.cmd)
                        CMD_STAT_READ:
                        begin
                            mbox_next[0]   = status_entry(v[3:0]);
                            mbox_pos_next  = 2'd0;
                            mbox_left_next = 2'd1;
                            status_next    = STAT_LAST_BYTE;
                            in_full_next   = 1'b1;
                            last_cmd_next  = 8'(v + 8'd1);
                        end
                        CMD_BURST_ARM:
                        begin
                            burst_left_next = BURST_W'(BURST_LENGTH);
                            burst_on_next   = 1'b1;
                        end
                        CMD_AUX_READ:
                        begin
                            mbox_next[0]   = 8'h00;
                            mbox_pos_next  = 2'd0;
                            mbox_left_next = 2'd1;
                            status_next    = STAT_LAST_BYTE;
                            in_full_next   = 1'b1;
                        end
                        CMD_MY_TALK:   talk_next[MY_ADDR]   = 1'b1;
                        CMD_MY_LISTEN: listen_next[MY_ADDR] = 1'b1;
                        CMD_IGNORE:    last_cmd_next = last_cmd_reg;
                        CMD_CREG_READ:
                        begin
                            mbox_next[0]   = aux_reg;
                            mbox_pos_next  = 2'd0;
                            mbox_left_next = 2'd1;
                            status_next    = STAT_LAST_BYTE;
                            in_full_next   = 1'b1;
                        end
                        default:       last_cmd_next = v;
                    endcase
                end
                else
                begin
                    case (last_grp)
                        GRP_CREG_LO, GRP_CREG_HI:
                        begin
                            // only the aux register is ever read back
                            if (last_cmd_reg[CREG_IDX_W-1:0] == AUX_REG_IDX)
                            begin
                                aux_next = v;
                            end
                            last_cmd_next = 8'(last_cmd_reg + 8'd1);
                        end
                        GRP_MESSAGE:
                        begin
                            if (msg_cnt_reg != MSG_W'(MSG_BUFFER_SIZE - 1))
                            begin
                                msg_cnt_next = MSG_W'(msg_cnt_reg + 1'b1);
                            end
                            out_mend_next = ctrl_reg[CTRL_END_BIT];
                        end
                        GRP_ATN:
                        begin
                            case (q_data.atn)
                                ATN_LISTEN:   listen_next = listen_reg | atn_mask;
                                ATN_UNLISTEN: listen_next = '0;
                                ATN_TALK:     talk_next = talk_reg | atn_mask;
                                ATN_UNTALK:
                                begin
                                    talk_next    = '0;
                                    msg_cnt_next = '0;
                                end
                                default:      listen_next = listen_reg;
                            endcase
                        end
                        default: last_cmd_next = last_cmd_reg;
                    endcase
                end
            end
            ACC_ACK:
            begin
                out_rdata_next = ACK_VECTOR;
                mbox_next[0]   = {6'd0, pending_reg};
                mbox_next[1]   = {6'd0, pending_reg};
                mbox_pos_next  = 2'd0;
                mbox_left_next = 2'd2;
                status_next    = 8'h00;
                in_full_next   = 1'b1;
            end
            default: out_rdata_next = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            status_reg     <= '0;
            in_full_reg    <= 1'b0;
            mbox_reg[0]    <= '0;
            mbox_reg[1]    <= '0;
            mbox_pos_reg   <= '0;
            mbox_left_reg  <= '0;
            aux_reg        <= AUX_REG_RESET;
            last_cmd_reg   <= '0;
            listen_reg     <= '0;
            talk_reg       <= '0;
            msg_cnt_reg    <= '0;
            burst_left_reg <= '0;
            burst_on_reg   <= 1'b0;
            burst_tail_reg <= 1'b0;
            ctrl_reg       <= '0;
            pending_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                status_reg     <= status_next;
                in_full_reg    <= in_full_next;
                mbox_reg[0]    <= mbox_next[0];
                mbox_reg[1]    <= mbox_next[1];
                mbox_pos_reg   <= mbox_pos_next;
                mbox_left_reg  <= mbox_left_next;
                aux_reg        <= aux_next;
                last_cmd_reg   <= last_cmd_next;
                listen_reg     <= listen_next;
                talk_reg       <= talk_next;
                msg_cnt_reg    <= msg_cnt_next;
                burst_left_reg <= burst_left_next;
                burst_on_reg   <= burst_on_next;
                burst_tail_reg <= burst_tail_next;
                ctrl_reg       <= ctrl_next;
                pending_reg    <= pending_next;
                out_valid_reg  <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_rdata_reg  <= out_rdata_next;
            out_irq_reg    <= out_irq_next;
            out_reason_reg <= out_reason_next;
            out_mend_reg   <= out_mend_next;
        end
    end
endmodule
`default_nettype wire

>>> design/io_translator_mailbox.sv
// io translator mailbox: host side of a bus translator
// req channel: one beat per host bus access (op, wdata); ops are status read,
//   input byte read, control write, output write and interrupt acknowledge
// rsp channel: exactly one beat per req beat, in order, carrying read data,
//   interrupt request and reason, listener and talker maps, end-of-message
//   flag and message byte count after the access
// a taken req beat is queued and then retired into the output register
// throughput: one access per cycle while rsp is ready; the front decodes
//   each beat into a two-entry queue and the back retires one queue entry per
//   cycle into the output register
// when rsp stalls the output register holds its beat, the queue fills and
//   req.ready drops once both queue entries are taken
// reset (rst_n low, asynchronous) empties the queue and output register and
//   loads the power-on state: mailbox empty, maps and counts clear, aux
//   control register at 2; accesses are taken in the first cycle after reset
`default_nettype none
module io_translator_mailbox (
    input  wire          clk,
    input  wire          rst_n,
    iotm_req_if.sink     req,
    iotm_rsp_if.source   rsp
);
    import iotm_pkg::*;

    logic q_full;
    logic q_push;
    acc_t q_push_data;
    logic q_pop;
    acc_t q_pop_data;
    logic q_valid;

    iotm_front u_front (
        .req       (req),
        .q_full    (q_full),
        .push      (q_push),
        .push_data (q_push_data)
    );

    iotm_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_pop_data),
        .not_empty (q_valid)
    );

    iotm_exec u_exec (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_data  (q_pop_data),
        .pop     (q_pop),
        .rsp     (rsp)
    );
endmodule
`default_nettype wire

>>> design/iotm_checker.sv
`default_nettype none
`include "io_translator_mailbox_macros.svh"
module iotm_checker (
    input wire       clk,
    input wire       rst_n,
    input wire       rsp_valid,
    input wire       rsp_ready,
    input wire [7:0] rsp_rdata,
    input wire       rsp_int_request,
    input wire [1:0] rsp_int_reason,
    input wire       rsp_message_end
);
    import iotm_pkg::*;

    `IOTM_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "rsp beat dropped")
    `IOTM_ASSERT_NOW(a_reason_quiet, rsp_valid && !rsp_int_request, rsp_int_reason == REASON_NONE, "reason without interrupt")
    `IOTM_ASSERT_NOW(a_reason_known, rsp_valid && rsp_int_request, rsp_int_reason == REASON_BURST || rsp_int_reason == REASON_RESET, "unknown interrupt reason")
    `IOTM_ASSERT_NOW(a_irq_on_write, rsp_valid && rsp_int_request, rsp_rdata == 8'h00 && !rsp_message_end, "interrupt on a read or data byte")
    `IOTM_ASSERT_NOW(a_mend_on_write, rsp_valid && rsp_message_end, rsp_rdata == 8'h00, "message end with read data")
endmodule

bind io_translator_mailbox iotm_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_rdata       (rsp.rdata),
    .rsp_int_request (rsp.int_request),
    .rsp_int_reason  (rsp.int_reason),
    .rsp_message_end (rsp.message_end)
);
`default_nettype wire

>>> verif/tb_io_translator_mailbox.sv
`default_nettype none
module tb_io_translator_mailbox;
    timeunit 1ns;
    timeprecision 1ps;

    import iotm_pkg::*;

    localparam logic [2:0] OP_NO_ACCESS = 3'd7;

    // command bytes written in command mode
    localparam logic [7:0] C_STAT_READ    = 8'h00;
    localparam logic [7:0] C_BURST_WRITE  = 8'h20;
    localparam logic [7:0] C_BURST_READ   = 8'h21;
    localparam logic [7:0] C_MAILBOX_ZERO = 8'h44;
    localparam logic [7:0] C_MY_TALK      = 8'h45;
    localparam logic [7:0] C_MY_LISTEN    = 8'h46;
    localparam logic [7:0] C_IGNORED      = 8'h50;
    localparam logic [7:0] C_AUX_READ     = 8'h70;
    localparam logic [7:0] C_CREG_WRITE   = 8'h80;
    localparam logic [7:0] C_MESSAGE      = 8'hA0;
    localparam logic [7:0] C_ATN          = 8'hB0;

    // bus addressing bytes
    localparam logic [7:0] C_LISTEN_BASE = 8'h20;
    localparam logic [7:0] C_UNLISTEN    = 8'h3F;
    localparam logic [7:0] C_TALK_BASE   = 8'h40;
    localparam logic [7:0] C_UNTALK      = 8'h5F;

    localparam logic [3:0] G_STAT  = 4'h0;
    localparam logic [3:0] G_BURST = 4'h2;
    localparam logic [3:0] G_ADDR  = 4'h4;
    localparam logic [3:0] G_IGN_A = 4'h5;
    localparam logic [3:0] G_IGN_B = 4'h6;
    localparam logic [3:0] G_AUX   = 4'h7;
    localparam logic [3:0] G_IGN_C = 4'hC;
    localparam logic [3:0] G_IGN_D = 4'hD;

    // status table, entry 0 in the low byte
    localparam logic [127:0] STAT_TABLE =
        {72'h0, 8'h01, 8'hA0, 8'h22, 8'h00, 8'hFC, 8'h00, 8'h01};

    localparam int DRAIN_CYCLES = 8;
    localparam int PHASE_ITEMS  = 35;

    typedef struct packed {
        logic [7:0]       rdata;
        logic             int_request;
        logic [1:0]       int_reason;
        logic [MAP_W-1:0] listen_map;
        logic [MAP_W-1:0] talk_map;
        logic             message_end;
        logic [8:0]       message_length;
    } access_result_t;

    typedef struct {
        logic [2:0]     op;
        logic [7:0]     wdata;
        bit             typed;
        access_result_t want;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    iotm_req_if req_ch();
    iotm_rsp_if rsp_ch();

    io_translator_mailbox dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    access_result_t expected_results[$];
    stim_row_t      stim_rows[$];
    int             mismatches = 0;
    int             accesses_sent = 0;
    int             send_idle_pct = 0;
    int             recv_idle_pct = 0;
    int             stall_cycles = 0;

    // translator state as seen by the host
    logic [7:0]       m_flags;
    logic             m_in_full;
    logic [7:0]       m_box [2];
    logic [1:0]       m_box_pos;
    logic [1:0]       m_box_left;
    logic [7:0]       m_creg [CONTROL_REG_COUNT];
    logic [7:0]       m_last_cmd;
    logic [MAP_W-1:0] m_listen;
    logic [MAP_W-1:0] m_talk;
    int               m_msg_cnt;
    int               m_burst_left;
    logic             m_burst_on;
    logic             m_burst_tail;
    logic [7:0]       m_ctrl;
    logic [1:0]       m_pending;

    function automatic access_result_t plain_result(input logic [7:0] rd, input logic irq,
                                                    input logic [1:0] rsn);
        access_result_t r;
        r = '0;
        r.rdata = rd;
        r.int_request = irq;
        r.int_reason = rsn;
        return r;
    endfunction

    task automatic fill_mailbox(input logic [7:0] b);
        m_box[0] = b;
        m_box_pos = '0;
        m_box_left = 2'd1;
        m_flags = STAT_LAST_BYTE;
        m_in_full = 1'b1;
    endtask

    task automatic predict_access(input logic [2:0] op, input logic [7:0] wd,
                                  output access_result_t r);
        logic [7:0]  old;
        logic [7:0]  v7;
        logic [31:0] bitv;
        r = '0;
        case (op)
            OP_STATUS:
            begin
                r.rdata = (m_flags & STAT_READ_MASK) | {7'd0, m_in_full};
            end
            OP_READ_IN:
            begin
                r.rdata = EMPTY_READ;
                if (m_box_left != 0)
                begin
                    if (m_in_full)
                    begin
                        r.rdata = m_box[m_box_pos[0]];
                        m_box_pos = m_box_pos + 2'd1;
                        m_box_left = m_box_left - 2'd1;
                        m_in_full = 1'b0;
                    end
                    if (m_box_left == 0)
                        m_flags = m_flags | STAT_LAST_BYTE;
                    else
                    begin
                        m_flags = m_flags & ~STAT_LAST_BYTE;
                        m_in_full = 1'b1;
                    end
                end
            end
            OP_CTRL:
            begin
                old = m_ctrl;
                m_ctrl = wd;
                if (wd[CTRL_RESET_BIT] && !old[CTRL_RESET_BIT])
                    m_flags = STAT_RESET_DONE;
                if (old[CTRL_HOLD_BIT] && !wd[CTRL_HOLD_BIT])
                begin
                    m_pending = REASON_RESET;
                    r.int_request = 1'b1;
                    r.int_reason = REASON_RESET;
                end
            end
            OP_OUT:
            begin
                if (m_burst_on)
                begin
                    if (m_burst_left > 0)
                        m_burst_left--;
                    if (m_burst_left == 0)
                    begin
                        m_burst_on = 1'b0;
                        m_burst_tail = 1'b1;
                        m_pending = REASON_BURST;
                        r.int_request = 1'b1;
                        r.int_reason = REASON_BURST;
                    end
                end
                else if (m_burst_tail)
                    m_burst_tail = 1'b0;
                else if (m_ctrl[CTRL_COM_BIT])
                begin
                    case (wd[7:4])
                        G_STAT:
                        begin
                            fill_mailbox(STAT_TABLE[wd[3:0]*8 +: 8]);
                            m_last_cmd = wd + 8'd1;
                        end
                        G_BURST:
                        begin
                            if (wd == C_BURST_WRITE)
                            begin
                                m_burst_left = BURST_LENGTH;
                                m_burst_on = 1'b1;
                            end
                            m_last_cmd = wd;
                        end
                        G_ADDR:
                        begin
                            m_last_cmd = wd;
                            if (wd[3:0] == C_MAILBOX_ZERO[3:0])
                                fill_mailbox(8'h00);
                            else if (wd[3:0] == C_MY_TALK[3:0])
                                m_talk[MY_ADDR] = 1'b1;
                            else if (wd[3:0] == C_MY_LISTEN[3:0])
                                m_listen[MY_ADDR] = 1'b1;
                        end
                        G_IGN_A, G_IGN_B, G_IGN_C, G_IGN_D:
                        begin
                        end
                        G_AUX:
                        begin
                            m_last_cmd = wd;
                            fill_mailbox(m_creg[AUX_REG_IDX]);
                        end
                        default:
                            m_last_cmd = wd;
                    endcase
                end
                else
                begin
                    case (m_last_cmd[7:4])
                        GRP_CREG_LO, GRP_CREG_HI:
                        begin
                            m_creg[m_last_cmd[4:0]] = wd;
                            m_last_cmd = m_last_cmd + 8'd1;
                        end
                        GRP_MESSAGE:
                        begin
                            m_msg_cnt++;
                            if (m_msg_cnt >= MSG_BUFFER_SIZE)
                                m_msg_cnt = MSG_BUFFER_SIZE - 1;
                            if (m_ctrl[CTRL_END_BIT])
                                r.message_end = 1'b1;
                        end
                        GRP_ATN:
                        begin
                            v7 = {1'b0, wd[6:0]};
                            bitv = 32'd1 << wd[4:0];
                            if (v7 >= C_LISTEN_BASE && v7 < C_UNLISTEN)
                                m_listen = m_listen | bitv[MAP_W-1:0];
                            else if (v7 == C_UNLISTEN)
                                m_listen = '0;
                            else if (v7 >= C_TALK_BASE && v7 < C_UNTALK)
                                m_talk = m_talk | bitv[MAP_W-1:0];
                            else if (v7 == C_UNTALK)
                            begin
                                m_talk = '0;
                                m_msg_cnt = 0;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            OP_ACK:
            begin
                r.rdata = ACK_VECTOR;
                m_box[0] = {6'd0, m_pending};
                m_box[1] = {6'd0, m_pending};
                m_box_pos = '0;
                m_box_left = 2'd2;
                m_flags = '0;
                m_in_full = 1'b1;
            end
            default:
            begin
            end
        endcase
        r.listen_map = m_listen;
        r.talk_map = m_talk;
        r.message_length = m_msg_cnt[8:0];
    endtask

    task automatic send_access(input logic [2:0] op, input logic [7:0] wd, input bit typed,
                               input access_result_t want);
        access_result_t r;
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.op <= op;
        req_ch.wdata <= wd;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        predict_access(op, wd, r);
        expected_results.push_back(typed ? want : r);
        accesses_sent++;
    endtask

    task automatic put(input logic [2:0] op, input logic [7:0] wd);
        send_access(op, wd, 1'b0, '0);
    endtask

    task automatic set_control(input bit com);
        logic [7:0] cv;
        cv = 8'($urandom);
        cv[CTRL_COM_BIT] = com;
        put(OP_CTRL, cv);
    endtask

    task automatic add_row(input logic [2:0] op, input logic [7:0] wd, input bit typed,
                           input access_result_t want);
        stim_row_t row;
        row.op = op;
        row.wdata = wd;
        row.typed = typed;
        row.want = want;
        stim_rows.push_back(row);
    endtask

    task automatic drain_results();
        req_ch.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic burst_sequence();
        set_control(1'b1);
        put(OP_OUT, C_BURST_WRITE);
        repeat (BURST_LENGTH)
        begin
            if ($urandom_range(15) == 0)
                put(OP_STATUS, 8'($urandom));
            put(OP_OUT, 8'($urandom));
        end
        put(OP_OUT, 8'($urandom));
        put(OP_ACK, 8'($urandom));
        put(OP_READ_IN, 8'($urandom));
        put(OP_READ_IN, 8'($urandom));
    endtask

    task automatic random_sequence();
        int         kind;
        int         n;
        int         sel;
        logic [7:0] b;
        kind = $urandom_range(9);
        case (kind)
            0:
            begin
                n = $urandom_range(1, 4);
                repeat (n) put(3'($urandom_range(7)), 8'($urandom));
            end
            1:
            begin
                put(OP_STATUS, 8'($urandom));
                put(OP_ACK, 8'($urandom));
                repeat ($urandom_range(1, 3)) put(OP_READ_IN, 8'($urandom));
            end
            2, 8:
            begin
                set_control(1'b1);
                b = 8'($urandom);
                if (b == C_BURST_WRITE)
                    b = C_BURST_READ;
                put(OP_OUT, b);
                put(OP_STATUS, 8'($urandom));
                repeat ($urandom_range(1, 2)) put(OP_READ_IN, 8'($urandom));
            end
            3:
            begin
                set_control(1'b1);
                put(OP_OUT, C_CREG_WRITE | 8'($urandom_range(31)));
                set_control(1'b0);
                n = $urandom_range(1, 6);
                repeat (n) put(OP_OUT, 8'($urandom));
                set_control(1'b1);
                put(OP_OUT, C_AUX_READ);
                put(OP_READ_IN, 8'($urandom));
            end
            4:
            begin
                set_control(1'b1);
                put(OP_OUT, C_MESSAGE | 8'($urandom_range(15)));
                set_control(1'b0);
                n = $urandom_range(1, 8);
                repeat (n) put(OP_OUT, 8'($urandom));
            end
            5:
            begin
                set_control(1'b1);
                put(OP_OUT, C_ATN | 8'($urandom_range(15)));
                set_control(1'b0);
                n = $urandom_range(1, 6);
                repeat (n)
                begin
                    sel = $urandom_range(9);
                    if (sel == 0)
                        b = C_UNLISTEN;
                    else if (sel == 1)
                        b = C_UNTALK;
                    else if (sel < 8)
                    begin
                        b = 8'($urandom_range(C_LISTEN_BASE, C_UNTALK));
                        b[7] = 1'($urandom_range(1));
                    end
                    else
                        b = 8'($urandom);
                    put(OP_OUT, b);
                end
            end
            6:
            begin
                put(OP_CTRL, 8'($urandom));
                put(OP_STATUS, 8'($urandom));
                put(OP_ACK, 8'($urandom));
                repeat (2) put(OP_READ_IN, 8'($urandom));
            end
            7:
            begin
                set_control(1'b1);
                sel = $urandom_range(5);
                case (sel)
                    0: b = C_MY_TALK;
                    1: b = C_MY_LISTEN;
                    2: b = C_MAILBOX_ZERO;
                    3: b = C_BURST_READ;
                    4: b = C_IGNORED | 8'($urandom_range(15));
                    default: b = C_STAT_READ | 8'($urandom_range(15));
                endcase
                put(OP_OUT, b);
                put(OP_READ_IN, 8'($urandom));
            end
            default:
            begin
                set_control(1'b0);
                repeat ($urandom_range(1, 4)) put(OP_OUT, 8'($urandom));
            end
        endcase
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s expected %0h got %0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin : result_check
        access_result_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result beat with nothing expected");
                mismatches++;
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("rdata", 32'(want.rdata), 32'(rsp_ch.rdata));
                check_field("int_request", 32'(want.int_request), 32'(rsp_ch.int_request));
                check_field("int_reason", 32'(want.int_reason), 32'(rsp_ch.int_reason));
                check_field("listen_map", 32'(want.listen_map), 32'(rsp_ch.listen_map));
                check_field("talk_map", 32'(want.talk_map), 32'(rsp_ch.talk_map));
                check_field("message_end", 32'(want.message_end), 32'(rsp_ch.message_end));
                check_field("message_length", 32'(want.message_length),
                            32'(rsp_ch.message_length));
            end
        end
    end

    // receiver: random stalls plus a long hold-off on request
    initial
    begin
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_cycles > 0)
            begin
                rsp_ch.ready <= 1'b0;
                stall_cycles--;
            end
            else
                rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial
    begin
        #2_000_000;
        $display("io_translator_mailbox verification failed");
        $finish;
    end

    initial
    begin
        req_ch.valid = 1'b0;
        req_ch.op = OP_STATUS;
        req_ch.wdata = 8'h00;

        m_flags = '0;
        m_in_full = 1'b0;
        m_box[0] = '0;
        m_box[1] = '0;
        m_box_pos = '0;
        m_box_left = '0;
        foreach (m_creg[i])
            m_creg[i] = '0;
        m_creg[16] = AUX_REG_RESET;
        m_creg[17] = 8'h0d;
        m_creg[18] = 8'h0a;
        m_last_cmd = '0;
        m_listen = '0;
        m_talk = '0;
        m_msg_cnt = 0;
        m_burst_left = 0;
        m_burst_on = 1'b0;
        m_burst_tail = 1'b0;
        m_ctrl = '0;
        m_pending = REASON_NONE;

        // power-on reads, reset handshake bits, ack vector
        add_row(OP_STATUS, 8'h00, 1'b1, plain_result(8'h00, 1'b0, REASON_NONE));
        add_row(OP_READ_IN, 8'hFF, 1'b1, plain_result(EMPTY_READ, 1'b0, REASON_NONE));
        add_row(OP_CTRL, 8'h81, 1'b1, plain_result(8'h00, 1'b0, REASON_NONE));
        add_row(OP_STATUS, 8'h00, 1'b1, plain_result(STAT_RESET_DONE, 1'b0, REASON_NONE));
        add_row(OP_CTRL, 8'h03, 1'b1, plain_result(8'h00, 1'b1, REASON_RESET));
        add_row(OP_ACK, 8'h00, 1'b1, plain_result(ACK_VECTOR, 1'b0, REASON_NONE));
        add_row(OP_READ_IN, 8'h00, 1'b0, '0);
        add_row(OP_READ_IN, 8'h00, 1'b0, '0);
        add_row(OP_READ_IN, 8'h00, 1'b0, '0);
        // commands
        add_row(OP_OUT, C_STAT_READ | 8'h05, 1'b0, '0);
        add_row(OP_READ_IN, 8'h00, 1'b0, '0);
        add_row(OP_OUT, C_MY_TALK, 1'b0, '0);
        add_row(OP_OUT, C_MY_LISTEN, 1'b0, '0);
        add_row(OP_OUT, C_IGNORED, 1'b0, '0);
        add_row(OP_OUT, 8'h9F, 1'b0, '0);
        // data mode: last control register, then wrap into the message group
        add_row(OP_CTRL, 8'h00, 1'b0, '0);
        add_row(OP_OUT, 8'hFF, 1'b0, '0);
        add_row(OP_OUT, 8'h00, 1'b0, '0);
        add_row(OP_CTRL, 8'h04, 1'b0, '0);
        add_row(OP_OUT, 8'h7F, 1'b0, '0);
        add_row(OP_CTRL, 8'h02, 1'b0, '0);
        add_row(OP_OUT, C_AUX_READ, 1'b0, '0);
        add_row(OP_OUT, 8'hBF, 1'b0, '0);
        add_row(OP_CTRL, 8'h00, 1'b0, '0);
        add_row(OP_OUT, C_UNLISTEN, 1'b0, '0);
        add_row(OP_OUT, C_UNTALK, 1'b0, '0);
        add_row(OP_NO_ACCESS, 8'hFF, 1'b0, '0);

        send_idle_pct = 23;
        recv_idle_pct = 76;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        foreach (stim_rows[i])
            send_access(stim_rows[i].op, stim_rows[i].wdata, stim_rows[i].typed,
                        stim_rows[i].want);

        stall_cycles = 120;
        while (accesses_sent < 30 + PHASE_ITEMS)
            random_sequence();
        burst_sequence();
        drain_results();

        send_idle_pct = 76;
        recv_idle_pct = 23;
        while (accesses_sent < 30 + 2 * PHASE_ITEMS + BURST_LENGTH + 20)
            random_sequence();
        drain_results();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        while (accesses_sent < 30 + 3 * PHASE_ITEMS + BURST_LENGTH + 20)
            random_sequence();
        drain_results();

        if (mismatches == 0 && expected_results.size() == 0)
            $display("io_translator_mailbox verification clean");
        else
            $display("io_translator_mailbox verification failed");
        $finish;
    end
endmodule
`default_nettype wire
